FILE: hw/rtl/disk_arm_request_scheduler_core_defines.svh
// Assertion macros shared by the scheduler RTL.
// In synthesis builds the macros expand to nothing.
`ifndef DISK_ARM_REQUEST_SCHEDULER_CORE_DEFINES_SVH
`define DISK_ARM_REQUEST_SCHEDULER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define DARS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

`define DARS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`else

`define DARS_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define DARS_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: hw/rtl/dars_pkg.sv
`timescale 1ns / 1ps

package dars_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int CYL_COUNT   = 1024;

  localparam int CYL_W       = 10;
  localparam int STAMP_W     = 40;
  localparam int SUM_W       = 48;
  localparam int SERVED_W    = 32;
  localparam int COST_W      = 12;
  localparam int STATUS_W    = 2;
  localparam int MODE_W      = 2;
  localparam int LIMIT_W     = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;
  localparam int ALU_W       = 48;

  localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int LIM_CMP_W   = (QCNT_W > LIMIT_W) ? QCNT_W : LIMIT_W;
  localparam int COST_CALC_W = COST_W + 2;

  localparam int COST_BASE    = 124;
  localparam int COST_PER_CYL = 3;
  localparam int COST_STILL   = 84;
  localparam int COST_MAX     = 4095;

  localparam logic [ALU_W-1:0]    STAMP_MAX  = ALU_W'({STAMP_W{1'b1}});
  localparam logic [ALU_W-1:0]    SUM_MAX    = {SUM_W{1'b1}};
  localparam logic [SERVED_W-1:0] SERVED_MAX = {SERVED_W{1'b1}};

  localparam logic [MODE_W-1:0] MODE_FIFO  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SSTF  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CSCAN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ALGORITHM_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT    = 1'd1;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  localparam logic ACT_PUSH     = 1'b0;
  localparam logic ACT_DISPATCH = 1'b1;

  typedef struct packed {
    logic             action;
    logic [CYL_W-1:0] cylinder;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CYL_W-1:0]    served_cylinder;
    logic [COST_W-1:0]   step_cost;
    logic [STAMP_W-1:0]  request_wait;
    logic [SUM_W-1:0]    total_wait;
    logic [SERVED_W-1:0] served_count;
  } rsp_t;

  typedef struct packed {
    logic [CYL_W-1:0]   cyl;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic               en;
    logic               first;
    logic [QADDR_W-1:0] idx;
  } sel_ctrl_t;

  typedef struct packed {
    logic [QADDR_W-1:0] idx;
    entry_t             entry;
  } sel_pick_t;

  typedef enum logic [1:0] {
    ALU_CLOCK_ADD,
    ALU_WAIT_SUB,
    ALU_SUM_ADD
  } alu_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_COST,
    S_CLOCK,
    S_WAIT,
    S_SUM,
    S_SHIFT,
    S_EMIT
  } state_t;

endpackage

FILE: hw/rtl/dars_ram.sv
`timescale 1ns / 1ps

module dars_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/dars_sel.sv
`timescale 1ns / 1ps

module dars_sel (
  input  logic                          clk,
  input  logic                          rst,
  input  dars_pkg::sel_ctrl_t           ctrl,
  input  dars_pkg::entry_t              entry,
  input  logic [dars_pkg::CYL_W-1:0]    arm,
  input  logic [dars_pkg::MODE_W-1:0]   mode,
  output dars_pkg::sel_pick_t           pick
);

  import dars_pkg::*;

  logic [CYL_W:0]   diff;
  logic             at_or_above;
  logic [CYL_W-1:0] span;

  sel_pick_t        fb;
  logic [CYL_W-1:0] fb_d;
  sel_pick_t        lo;
  logic             up_found;
  sel_pick_t        up;
  logic [CYL_W-1:0] up_d;

  // One subtractor serves every entry of the scan in turn.
  assign diff        = {1'b0, entry.cyl} - {1'b0, arm};
  assign at_or_above = ~diff[CYL_W];
  assign span        = at_or_above ? diff[CYL_W-1:0] : CYL_W'(~diff[CYL_W-1:0] + 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      up_found <= 1'b0;
    end else if (ctrl.en) begin
      if (ctrl.first) begin
        up_found <= at_or_above;
      end else if (at_or_above) begin
        up_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      if (ctrl.first) begin
        fb   <= '{idx: ctrl.idx, entry: entry};
        fb_d <= span;
        lo   <= '{idx: ctrl.idx, entry: entry};
        up   <= '{idx: ctrl.idx, entry: entry};
        up_d <= span;
      end else begin
        if (mode == MODE_SSTF && span < fb_d) begin
          fb   <= '{idx: ctrl.idx, entry: entry};
          fb_d <= span;
        end
        if (entry.cyl < lo.entry.cyl) begin
          lo <= '{idx: ctrl.idx, entry: entry};
        end
        if (at_or_above && (!up_found || span < up_d)) begin
          up   <= '{idx: ctrl.idx, entry: entry};
          up_d <= span;
        end
      end
    end
  end

  // Any mode other than nearest-first and circular scan keeps the oldest entry.
  always_comb begin
    if (mode == MODE_CSCAN) begin
      pick = up_found ? up : lo;
    end else begin
      pick = fb;
    end
  end

endmodule

FILE: hw/rtl/dars_alu.sv
`timescale 1ns / 1ps

module dars_alu (
  input  dars_pkg::alu_op_t             op,
  input  logic [dars_pkg::ALU_W-1:0]    a,
  input  logic [dars_pkg::ALU_W-1:0]    b,
  output logic [dars_pkg::ALU_W-1:0]    y
);

  import dars_pkg::*;

  logic [ALU_W:0]   sum;
  logic [ALU_W-1:0] diff;

  assign sum  = {1'b0, a} + {1'b0, b};
  assign diff = a - b;

  always_comb begin
    case (op)
      ALU_CLOCK_ADD: begin
        y = (sum > {1'b0, STAMP_MAX}) ? STAMP_MAX : sum[ALU_W-1:0];
      end
      ALU_WAIT_SUB: begin
        y = (diff > STAMP_MAX) ? STAMP_MAX : diff;
      end
      ALU_SUM_ADD: begin
        y = (sum > {1'b0, SUM_MAX}) ? SUM_MAX : sum[ALU_W-1:0];
      end
      default: begin
        y = sum[ALU_W-1:0];
      end
    endcase
  end

endmodule

FILE: hw/rtl/disk_arm_request_scheduler_core.sv
// Sequence: a push, a refused push or an empty dispatch goes from S_IDLE straight to
// S_EMIT; a dispatch first passes through S_SCAN, S_COST, S_CLOCK, S_WAIT, S_SUM, S_SHIFT.
// Flow: one beat at a time; the next is taken when the result is registered, and a
// dispatch takes longer the fuller the queue, set by the single read port of the queue RAM.
// Reset: synchronous; clears count, arm, clock, totals, mode; sets limit to the depth.
`timescale 1ns / 1ps
`include "disk_arm_request_scheduler_core_defines.svh"

module disk_arm_request_scheduler_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  dars_pkg::req_t                     req_data,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output dars_pkg::rsp_t                     rsp_data,
  input  logic                               cfg_we,
  input  logic [dars_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dars_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import dars_pkg::*;

  state_t              state;
  state_t              state_next;

  logic [MODE_W-1:0]   mode;
  logic [LIMIT_W-1:0]  limit;
  logic [QCNT_W-1:0]   count;
  logic [CYL_W-1:0]    arm;
  logic [STAMP_W-1:0]  service_clock;
  logic [SUM_W-1:0]    wait_sum;
  logic [SERVED_W-1:0] done_count;

  logic [QCNT_W-1:0]   cnt;
  sel_pick_t           tgt;
  logic [COST_W-1:0]   cost;
  logic [STAMP_W-1:0]  req_wait;

  logic [STATUS_W-1:0] res_status;
  logic [CYL_W-1:0]    res_cyl;
  logic [COST_W-1:0]   res_cost;
  logic [STAMP_W-1:0]  res_wait;

  logic                accept;
  logic                out_free;
  logic                full;
  logic [LIM_CMP_W-1:0] limit_eff;
  logic [CYL_W-1:0]    push_cyl;
  logic                scan_done;
  logic                shift_done;

  logic                ram_wr_en;
  logic [QADDR_W-1:0]  ram_wr_addr;
  entry_t              ram_wr_data;
  logic [QADDR_W-1:0]  ram_rd_addr;
  entry_t              ram_rd_data;

  sel_ctrl_t           sel_ctrl;
  sel_pick_t           pick;

  alu_op_t             alu_op;
  logic [ALU_W-1:0]    alu_a;
  logic [ALU_W-1:0]    alu_b;
  logic [ALU_W-1:0]    alu_y;

  logic [CYL_W:0]       move_diff;
  logic [CYL_W-1:0]     move_dist;
  logic [COST_CALC_W-1:0] cost_calc;
  logic [COST_W-1:0]    cost_sat;

  assign req_stall  = (state != S_IDLE);
  assign accept     = req_valid && !req_stall;
  assign out_free   = !rsp_valid || !rsp_stall;
  assign scan_done  = (cnt == count);
  assign shift_done = (cnt == count);

  assign limit_eff = (LIM_CMP_W'(limit) > LIM_CMP_W'(QUEUE_DEPTH)) ?
                     LIM_CMP_W'(QUEUE_DEPTH) : LIM_CMP_W'(limit);
  assign full      = (LIM_CMP_W'(count) >= limit_eff);

  assign push_cyl = ((CYL_W + 1)'(req_data.cylinder) > (CYL_W + 1)'(CYL_COUNT - 1)) ?
                    CYL_W'(CYL_COUNT - 1) : req_data.cylinder;

  assign move_diff = {1'b0, pick.entry.cyl} - {1'b0, arm};
  assign move_dist = move_diff[CYL_W] ? CYL_W'(~move_diff[CYL_W-1:0] + 1'b1) :
                     move_diff[CYL_W-1:0];
  assign cost_calc = (move_dist == '0) ? COST_CALC_W'(COST_STILL) :
                     COST_CALC_W'(COST_BASE) +
                     COST_CALC_W'(move_dist) * COST_CALC_W'(COST_PER_CYL);
  assign cost_sat  = (cost_calc > COST_CALC_W'(COST_MAX)) ? COST_W'(COST_MAX) :
                     cost_calc[COST_W-1:0];

  dars_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  dars_sel u_sel (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (sel_ctrl),
    .entry (ram_rd_data),
    .arm   (arm),
    .mode  (mode),
    .pick  (pick)
  );

  dars_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_data.action == ACT_DISPATCH && count != '0) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_COST;
        end
      end
      S_COST:  state_next = S_CLOCK;
      S_CLOCK: state_next = S_WAIT;
      S_WAIT:  state_next = S_SUM;
      S_SUM:   state_next = S_SHIFT;
      S_SHIFT: begin
        if (shift_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = count[QADDR_W-1:0];
    ram_wr_data = '{cyl: push_cyl, stamp: service_clock};
    ram_rd_addr = cnt[QADDR_W-1:0];
    sel_ctrl    = '{en: 1'b0, first: 1'b0, idx: QADDR_W'(cnt - 1'b1)};
    alu_op      = ALU_SUM_ADD;
    alu_a       = ALU_W'(wait_sum);
    alu_b       = ALU_W'(req_wait);
    case (state)
      S_IDLE: begin
        ram_wr_en = accept && (req_data.action == ACT_PUSH) && !full;
      end
      S_SCAN: begin
        sel_ctrl.en    = (cnt != '0);
        sel_ctrl.first = (cnt == QCNT_W'(1));
      end
      S_CLOCK: begin
        alu_op = ALU_CLOCK_ADD;
        alu_a  = ALU_W'(service_clock);
        alu_b  = ALU_W'(cost);
      end
      S_WAIT: begin
        alu_op = ALU_WAIT_SUB;
        alu_a  = ALU_W'(service_clock);
        alu_b  = ALU_W'(tgt.entry.stamp);
      end
      S_SHIFT: begin
        // Entry cnt-1 was read last cycle and moves down one place.
        ram_wr_en   = (cnt >= QCNT_W'(tgt.idx) + QCNT_W'(2));
        ram_wr_addr = QADDR_W'(cnt - QCNT_W'(2));
        ram_wr_data = ram_rd_data;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      mode          <= MODE_FIFO;
      limit         <= LIMIT_W'(QUEUE_DEPTH);
      count         <= '0;
      arm           <= '0;
      service_clock <= '0;
      wait_sum      <= '0;
      done_count    <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ALGORITHM_MODE: mode  <= cfg_data[MODE_W-1:0];
          CFG_QUEUE_LIMIT:    limit <= cfg_data[LIMIT_W-1:0];
          default: begin
          end
        endcase
      end
      if (ram_wr_en && state == S_IDLE) begin
        count <= count + 1'b1;
      end
      if (state == S_CLOCK) begin
        service_clock <= alu_y[STAMP_W-1:0];
      end
      if (state == S_SUM) begin
        wait_sum <= alu_y[SUM_W-1:0];
      end
      if (state == S_SHIFT && shift_done) begin
        count <= count - 1'b1;
        arm   <= tgt.entry.cyl;
        if (done_count != SERVED_MAX) begin
          done_count <= done_count + 1'b1;
        end
      end
      if (state == S_EMIT && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cnt <= '0;
        if (accept) begin
          res_cyl  <= '0;
          res_cost <= '0;
          res_wait <= '0;
          if (req_data.action == ACT_PUSH) begin
            res_status <= full ? STAT_FULL : STAT_OK;
          end else begin
            res_status <= (count == '0) ? STAT_EMPTY : STAT_OK;
          end
        end
      end
      S_SCAN: begin
        if (!scan_done) begin
          cnt <= cnt + 1'b1;
        end
      end
      S_COST: begin
        cost <= cost_sat;
        tgt  <= pick;
      end
      S_WAIT: begin
        req_wait <= alu_y[STAMP_W-1:0];
      end
      S_SUM: begin
        cnt <= QCNT_W'(tgt.idx) + 1'b1;
      end
      S_SHIFT: begin
        if (!shift_done) begin
          cnt <= cnt + 1'b1;
        end else begin
          res_status <= STAT_OK;
          res_cyl    <= tgt.entry.cyl;
          res_cost   <= cost;
          res_wait   <= req_wait;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          rsp_data <= '{status:          res_status,
                        served_cylinder: res_cyl,
                        step_cost:       res_cost,
                        request_wait:    res_wait,
                        total_wait:      wait_sum,
                        served_count:    done_count};
        end
      end
      default: begin
      end
    endcase
  end

  `DARS_ASSERT_IMP(a_count_in_range, clk, rst, 1'b1, count <= QCNT_W'(QUEUE_DEPTH))
  `DARS_ASSERT_IMP(a_scan_needs_entries, clk, rst, state == S_SCAN, count != '0)
  `DARS_ASSERT_NXT(a_accept_leaves_idle, clk, rst, accept, state != S_IDLE)
  `DARS_ASSERT_NXT(a_dispatch_pops_one, clk, rst, state == S_SHIFT && shift_done,
                   count == $past(count) - QCNT_W'(1))

endmodule

FILE: bench/tb_disk_arm_request_scheduler_core.sv
`timescale 1ns / 1ps

module tb_disk_arm_request_scheduler_core;
  import dars_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNDEF = 2'd3;
  localparam longint unsigned CLOCK_CEIL = 64'hFF_FFFF_FFFF;
  localparam longint unsigned SUM_CEIL   = 64'hFFFF_FFFF_FFFF;
  localparam longint unsigned COUNT_CEIL = 64'hFFFF_FFFF;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 150;
  localparam int PHASES       = 10;
  localparam int PHASE_BEATS  = 75;

  typedef struct packed {
    logic typed;
    rsp_t result;
  } pinned_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    req_t                  beat;
    logic                  typed;
    rsp_t                  result;
  } plan_row_t;

  logic                  clk;
  logic                  rst;
  logic                  req_valid;
  logic                  req_stall;
  req_t                  req_data;
  logic                  rsp_valid;
  logic                  rsp_stall;
  rsp_t                  rsp_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int   gap_pct;
  int   stall_pct;
  logic hold_go;
  logic hold_off;
  int   mismatches;
  int   cycle_count;

  // Shadow copy of the scheduler state.
  int               q_cyl [QUEUE_DEPTH];
  longint unsigned  q_stamp [QUEUE_DEPTH];
  int               q_count;
  int               arm_pos;
  longint unsigned  svc_clock;
  longint unsigned  wait_total;
  longint unsigned  done_total;
  logic [MODE_W-1:0] mode_reg;
  int               limit_reg;

  pinned_t row_results [$];
  rsp_t    due_results [$];

  disk_arm_request_scheduler_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int cyl_gap(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int pick_entry();
    int best, best_d, d, low, low_c, up, up_d, i;
    bit found;
    best = 0;
    if (mode_reg == MODE_SSTF) begin
      best_d = cyl_gap(q_cyl[0], arm_pos);
      for (i = 1; i < q_count; i++) begin
        d = cyl_gap(q_cyl[i], arm_pos);
        if (d < best_d) begin
          best_d = d;
          best = i;
        end
      end
    end else if (mode_reg == MODE_CSCAN) begin
      found = 1'b0;
      up = 0;
      up_d = 0;
      low = 0;
      low_c = q_cyl[0];
      for (i = 0; i < q_count; i++) begin
        if (q_cyl[i] < low_c) begin
          low_c = q_cyl[i];
          low = i;
        end
        if (q_cyl[i] >= arm_pos) begin
          d = q_cyl[i] - arm_pos;
          if (!found || d < up_d) begin
            found = 1'b1;
            up = i;
            up_d = d;
          end
        end
      end
      best = found ? up : low;
    end
    return best;
  endfunction

  task automatic advance_scheduler(input req_t beat, output rsp_t r);
    int k, lim, i;
    longint unsigned cost, w;
    r = '0;
    r.status = STAT_OK;
    if (beat.action == ACT_PUSH) begin
      lim = (limit_reg < QUEUE_DEPTH) ? limit_reg : QUEUE_DEPTH;
      if (q_count >= lim) begin
        r.status = STAT_FULL;
      end else begin
        q_cyl[q_count] = beat.cylinder;
        q_stamp[q_count] = svc_clock;
        q_count++;
      end
    end else if (q_count == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      k = pick_entry();
      if (q_cyl[k] == arm_pos)
        cost = COST_STILL;
      else
        cost = COST_BASE + COST_PER_CYL * cyl_gap(q_cyl[k], arm_pos);
      if (cost > COST_MAX)
        cost = COST_MAX;
      svc_clock += cost;
      if (svc_clock > CLOCK_CEIL)
        svc_clock = CLOCK_CEIL;
      w = svc_clock - q_stamp[k];
      if (w > CLOCK_CEIL)
        w = CLOCK_CEIL;
      r.served_cylinder = CYL_W'(q_cyl[k]);
      r.step_cost = COST_W'(cost);
      r.request_wait = STAMP_W'(w);
      arm_pos = q_cyl[k];
      for (i = k + 1; i < q_count; i++) begin
        q_cyl[i - 1] = q_cyl[i];
        q_stamp[i - 1] = q_stamp[i];
      end
      q_count--;
      wait_total += w;
      if (wait_total > SUM_CEIL)
        wait_total = SUM_CEIL;
      if (done_total < COUNT_CEIL)
        done_total++;
    end
    r.total_wait = SUM_W'(wait_total);
    r.served_count = SERVED_W'(done_total);
  endtask

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want)
      report($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_stall <= hold_off || ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    hold_off = 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin : monitor
    rsp_t    predicted;
    rsp_t    want;
    pinned_t pin;
    if (!rst) begin
      if (cfg_we) begin
        if (cfg_index == CFG_ALGORITHM_MODE)
          mode_reg = cfg_data[MODE_W-1:0];
        else
          limit_reg = cfg_data[LIMIT_W-1:0];
      end
      if (req_valid && !req_stall) begin
        advance_scheduler(req_data, predicted);
        pin = row_results.pop_front();
        due_results.push_back(pin.typed ? pin.result : predicted);
      end
      if (rsp_valid && !rsp_stall) begin
        if (due_results.size() == 0) begin
          report("result beat with nothing outstanding");
        end else begin
          want = due_results.pop_front();
          check_field("status", rsp_data.status, want.status);
          check_field("served_cylinder", rsp_data.served_cylinder, want.served_cylinder);
          check_field("step_cost", rsp_data.step_cost, want.step_cost);
          check_field("request_wait", rsp_data.request_wait, want.request_wait);
          check_field("total_wait", rsp_data.total_wait, want.total_wait);
          check_field("served_count", rsp_data.served_count, want.served_count);
        end
      end
    end
  end

  task automatic send_beat(input req_t beat, input logic typed, input rsp_t result);
    pinned_t pin;
    cfg_we <= 1'b0;
    while ($urandom_range(0, 99) < gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    pin.typed = typed;
    pin.result = result;
    row_results.push_back(pin);
    req_valid <= 1'b1;
    req_data <= beat;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // The write enable is left high so that back-to-back writes need no gap.
  task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
    req_valid <= 1'b0;
    while (due_results.size() != 0 || row_results.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic send_random(input int count);
    int   sent, burst, push_pct, roll, n;
    req_t beat;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 32);
      case ($urandom_range(0, 2))
        0: begin
          push_pct = 90;
        end
        1: begin
          push_pct = 55;
        end
        default: begin
          push_pct = 15;
        end
      endcase
      for (n = 0; n < burst && sent < count; n++) begin
        beat.action = ($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_DISPATCH;
        roll = $urandom_range(0, 9);
        if (roll == 0)
          beat.cylinder = '0;
        else if (roll == 1)
          beat.cylinder = '1;
        else if (roll <= 3)
          beat.cylinder = CYL_W'(510 + $urandom_range(0, 3));
        else
          beat.cylinder = CYL_W'($urandom_range(0, CYL_COUNT - 1));
        send_beat(beat, 1'b0, '0);
        sent++;
      end
    end
  endtask

  function automatic plan_row_t beat_row(input logic act, input int cyl);
    plan_row_t r;
    r = '0;
    r.beat.action = act;
    r.beat.cylinder = CYL_W'(cyl);
    return r;
  endfunction

  function automatic plan_row_t typed_row(input logic act, input int cyl,
                                          input logic [STATUS_W-1:0] st, input int served,
                                          input int cost, input longint w,
                                          input longint tot, input longint cnt);
    plan_row_t r;
    r = beat_row(act, cyl);
    r.typed = 1'b1;
    r.result.status = st;
    r.result.served_cylinder = CYL_W'(served);
    r.result.step_cost = COST_W'(cost);
    r.result.request_wait = STAMP_W'(w);
    r.result.total_wait = SUM_W'(tot);
    r.result.served_count = SERVED_W'(cnt);
    return r;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = CFG_DATA_W'(val);
    return r;
  endfunction

  initial begin
    plan_row_t plan [$];
    int        phase_mode [PHASES];
    int        phase_limit [PHASES];
    int        p, r;

    rst = 1'b1;
    req_valid = 1'b0;
    req_data = '0;
    rsp_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    gap_pct = 0;
    stall_pct = 0;
    hold_go = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    q_count = 0;
    arm_pos = 0;
    svc_clock = 0;
    wait_total = 0;
    done_total = 0;
    mode_reg = MODE_FIFO;
    limit_reg = QUEUE_DEPTH;

    // Reset values first: oldest-first order and the full queue limit.
    plan.push_back(typed_row(ACT_DISPATCH, 1023, STAT_EMPTY, 0, 0, 0, 0, 0));
    plan.push_back(typed_row(ACT_PUSH, 0, STAT_OK, 0, 0, 0, 0, 0));
    plan.push_back(typed_row(ACT_DISPATCH, 0, STAT_OK, 0, 84, 84, 84, 1));
    plan.push_back(typed_row(ACT_PUSH, 1023, STAT_OK, 0, 0, 0, 84, 1));
    plan.push_back(typed_row(ACT_DISPATCH, 0, STAT_OK, 1023, 3193, 3193, 3277, 2));
    // A limit of zero refuses every push.
    plan.push_back(reg_row(CFG_QUEUE_LIMIT, 0));
    plan.push_back(typed_row(ACT_PUSH, 7, STAT_FULL, 0, 0, 0, 3277, 2));
    plan.push_back(reg_row(CFG_QUEUE_LIMIT, 2));
    plan.push_back(beat_row(ACT_PUSH, 300));
    plan.push_back(beat_row(ACT_PUSH, 700));
    plan.push_back(beat_row(ACT_PUSH, 5));
    plan.push_back(reg_row(CFG_ALGORITHM_MODE, MODE_SSTF));
    plan.push_back(beat_row(ACT_DISPATCH, 0));
    plan.push_back(beat_row(ACT_DISPATCH, 512));
    // Upward scan with ties and a wrap to the lowest cylinder; limit above the depth.
    plan.push_back(reg_row(CFG_ALGORITHM_MODE, MODE_CSCAN));
    plan.push_back(reg_row(CFG_QUEUE_LIMIT, 127));
    plan.push_back(beat_row(ACT_PUSH, 100));
    plan.push_back(beat_row(ACT_PUSH, 900));
    plan.push_back(beat_row(ACT_PUSH, 250));
    plan.push_back(beat_row(ACT_PUSH, 250));
    plan.push_back(beat_row(ACT_DISPATCH, 1));
    plan.push_back(beat_row(ACT_DISPATCH, 2));
    plan.push_back(beat_row(ACT_DISPATCH, 4));
    plan.push_back(beat_row(ACT_DISPATCH, 8));
    // The unused mode code falls back to oldest-first.
    plan.push_back(reg_row(CFG_ALGORITHM_MODE, MODE_UNDEF));
    plan.push_back(beat_row(ACT_PUSH, 40));
    plan.push_back(beat_row(ACT_PUSH, 20));
    plan.push_back(beat_row(ACT_DISPATCH, 0));
    plan.push_back(beat_row(ACT_DISPATCH, 0));

    phase_mode = '{MODE_SSTF, MODE_CSCAN, MODE_FIFO, MODE_UNDEF, MODE_CSCAN,
                   MODE_SSTF, MODE_CSCAN, MODE_FIFO, MODE_SSTF, MODE_CSCAN};
    phase_limit = '{64, 127, 1, 10, 64, 2, 33, 64, 100, 64};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < plan.size(); r++) begin
      if (plan[r].is_cfg)
        set_register(plan[r].reg_idx, plan[r].reg_val);
      else
        send_beat(plan[r].beat, plan[r].typed, plan[r].result);
    end

    for (p = 0; p < PHASES; p++) begin
      set_register(CFG_ALGORITHM_MODE, CFG_DATA_W'(phase_mode[p]));
      set_register(CFG_QUEUE_LIMIT, CFG_DATA_W'(phase_limit[p]));
      case (p % 4)
        0: begin
          gap_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          gap_pct = 78;
          stall_pct <= 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct <= 78;
        end
        default: begin
          gap_pct = 17;
          stall_pct <= 17;
        end
      endcase
      // The receiver holds off for a long stretch while beats keep coming.
      if (p == 4)
        hold_go = 1'b1;
      send_random(PHASE_BEATS);
    end

    req_valid <= 1'b0;
    stall_pct <= 0;
    while (due_results.size() != 0 || row_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
